### sv/lgrid_pkg.sv
// shared constants and command codes for the life automaton grid
package lgrid_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  localparam int CMD_W = 2;
  localparam int IDX_W = 5;
  localparam int CELLS_W = 32;
  localparam int REG_W = 6;
  localparam int REG_IDX_W = 2;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [REG_W-1:0] ROWS_RESET = 6'd32;
  localparam logic [REG_W-1:0] COLS_RESET = 6'd32;

  localparam logic [3:0] LIFE_BIRTH = 4'd3;
  localparam logic [3:0] LIFE_KEEP = 4'd2;

endpackage

### sv/life_automaton_grid.sv
// top level: grid memory, command handling and the generation sweep
//
// Input channel s_*: one item is a command. Load writes one row, step
// advances the whole grid one generation, read returns one row on m_*.
// Load and step give no output item; command 3 is dropped.
// Config channel cfg_*: index 0 sets rows_in_use, index 1 cols_in_use;
// cfg_ready is always high; writes must be made while the block is idle, which the block does not enforce.
// A load leaves s_tready high, so the next item may follow at once.
// A read registers the row, then moves it into the output register and raises
// m_tvalid once that register is free; s_tready is low in the read state.
// A step sweeps the rows through a three-row window, one row of all
// columns a cycle through the lanes, and keeps s_tready low until the
// sweep ends: it first fills the window, then fetches each row while the
// row two above it is written back.
// s_tready is high only between commands.
// Reset clears the per-row valid bits (all cells read as dead) and m_tvalid
// and sets both size registers to 32; there is no clearing pass.
// A stalled m_tready holds the read item in the output register; loads
// and steps go on meanwhile, a second read waits for the register.
module life_automaton_grid
  import lgrid_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // command[1:0], row_index[6:2], row_cells[38:7]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // out_row_index[4:0], out_row_cells[36:5]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CNT_W = $clog2(MAX_ROWS + 2);
  localparam int WIDE_W = 10;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GEN  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state, state_next;
  logic [REG_W-1:0] rows_in_use;
  logic [REG_W-1:0] cols_in_use;
  logic [CNT_W-1:0] cnt;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid;
  logic [MAX_COLS-1:0] rd_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  logic [MAX_COLS-1:0] wr_data;

  logic [MAX_COLS-1:0] win_above;
  logic [MAX_COLS-1:0] win_here;
  logic [MAX_COLS-1:0] win_below;
  logic [MAX_COLS-1:0] area;
  logic [MAX_COLS-1:0] new_row;

  logic [IDX_W-1:0] rd_row;
  logic             rd_ok;

  logic [CMD_W-1:0]   in_cmd;
  logic [IDX_W-1:0]   in_row;
  logic [CELLS_W-1:0] in_cells;
  logic               in_take;
  logic [WIDE_W-1:0]  in_row_wide;
  logic               in_row_ok;
  logic [AW-1:0]      in_addr;
  logic [63:0]        in_cells_wide;
  logic [63:0]        rd_data_wide;

  logic [WIDE_W-1:0] nr_wide;
  logic [CNT_W-1:0]  nr;
  logic [CNT_W-1:0]  cnt_m2;
  logic              out_free;

  assign in_cmd   = s_tdata[1:0];
  assign in_row   = s_tdata[6:2];
  assign in_cells = s_tdata[38:7];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = s_tvalid && s_tready;

  assign in_row_wide   = WIDE_W'(in_row);
  assign in_row_ok     = in_row_wide < WIDE_W'(MAX_ROWS);
  assign in_addr       = in_row_wide[AW-1:0];
  assign in_cells_wide = 64'(in_cells);

  // rows taking part, clipped to the grid
  assign nr_wide = (WIDE_W'(rows_in_use) < WIDE_W'(MAX_ROWS)) ?
                   WIDE_W'(rows_in_use) : WIDE_W'(MAX_ROWS);
  assign nr      = nr_wide[CNT_W-1:0];
  assign cnt_m2  = cnt - CNT_W'(2);

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_area
    assign area[j] = 7'(j) < 7'(cols_in_use);
  end

  assign win_below = (cnt <= nr) ? rd_data : '0;

  lgrid_row #(.COLS(MAX_COLS)) u_row (
    .above   (win_above),
    .here    (win_here),
    .below   (win_below),
    .area    (area),
    .new_row (new_row)
  );

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    rd_addr = in_addr;
    mem_we = 1'b0;
    wr_addr = in_addr;
    wr_data = in_cells_wide[MAX_COLS-1:0];
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (in_cmd)
            CMD_LOAD: mem_we = in_row_ok;
            CMD_STEP: state_next = ST_GEN;
            CMD_READ: begin
              rd_en = 1'b1;
              state_next = ST_READ;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_GEN: begin
        // row cnt is fetched while row cnt-2 is written back
        rd_en = cnt < nr;
        rd_addr = cnt[AW-1:0];
        mem_we = cnt >= CNT_W'(2);
        wr_addr = cnt_m2[AW-1:0];
        wr_data = new_row;
        if (cnt == CNT_W'(nr + CNT_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // grid memory, rows not yet written read as dead
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else begin
      state <= state_next;
      if (state == ST_GEN) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS) begin
          rows_in_use <= cfg_data;
        end else if (cfg_index == REG_COLS) begin
          cols_in_use <= cfg_data;
        end
      end
    end
  end

  // three-row window of the sweep
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      win_above <= '0;
      win_here <= '0;
    end else if (state == ST_GEN && cnt != '0) begin
      win_above <= win_here;
      win_here <= win_below;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_cmd == CMD_READ) begin
      rd_row <= in_row;
      rd_ok <= in_row_ok;
    end
  end

  assign rd_data_wide = 64'(rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_READ && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ && out_free) begin
      m_tdata <= {3'b000, (rd_ok ? rd_data_wide[CELLS_W-1:0] : CELLS_W'(0)), rd_row};
    end
  end

  a_gen_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN && mem_we) |-> (cnt_m2 < nr))
    else $error("sweep writes a row outside the rows in use");

  a_gen_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN) |-> (cnt <= CNT_W'(nr + CNT_W'(1))))
    else $error("sweep counter ran past its end");

  a_read_goes_out: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_cmd == CMD_READ) |=> (state == ST_READ))
    else $error("read item did not enter the read state");

  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_READ))
    else $error("output item raised outside a read");

  a_no_read_write_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && mem_we) |-> (rd_addr != wr_addr))
    else $error("grid memory read and written at one row");

endmodule

### sv/lgrid_lane.sv
// one cell lane: counts the eight neighbours and applies the b3/s23 rule
module lgrid_lane
  import lgrid_pkg::*;
(
  input  logic [7:0] nbr,
  input  logic       alive,
  output logic       next_alive
);

  logic [3:0] live_cnt;

  always_comb begin
    live_cnt = 4'(nbr[0]) + 4'(nbr[1]) + 4'(nbr[2]) + 4'(nbr[3])
             + 4'(nbr[4]) + 4'(nbr[5]) + 4'(nbr[6]) + 4'(nbr[7]);
    next_alive = (live_cnt == LIFE_BIRTH) || (alive && (live_cnt == LIFE_KEEP));
  end

endmodule

### sv/lgrid_row.sv
// row of cell lanes and the merge of their results into one new grid row
module lgrid_row
  import lgrid_pkg::*;
#(
  parameter int COLS = MAX_COLS_DEF
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] here,
  input  logic [COLS-1:0] below,
  input  logic [COLS-1:0] area,
  output logic [COLS-1:0] new_row
);

  logic [COLS+1:0] pad_above;
  logic [COLS+1:0] pad_here;
  logic [COLS+1:0] pad_below;
  logic [COLS-1:0] fresh;

  // cells outside the area and beyond the edges count as dead
  assign pad_above = {1'b0, above & area, 1'b0};
  assign pad_here  = {1'b0, here & area, 1'b0};
  assign pad_below = {1'b0, below & area, 1'b0};

  for (genvar j = 0; j < COLS; j++) begin : g_lane
    lgrid_lane u_lane (
      .nbr        ({pad_above[j+2:j], pad_here[j+2], pad_here[j], pad_below[j+2:j]}),
      .alive      (pad_here[j+1]),
      .next_alive (fresh[j])
    );
  end

  // columns outside the area keep what they hold
  assign new_row = (here & ~area) | (fresh & area);

endmodule
